// File: src/ghal_pkg.sv
// Shared types and constants for the generational handle allocator.
package ghal_pkg;

    localparam int SLOT_COUNT   = 1024;
    localparam int VERSION_BITS = 8;
    localparam int IDX_BITS     = 10;
    localparam int HANDLE_BITS  = 18;
    localparam int CNT_BITS     = $clog2(SLOT_COUNT + 1);

    localparam logic [1:0] CMD_NEW     = 2'd0;
    localparam logic [1:0] CMD_DESTROY = 2'd1;
    localparam logic [1:0] CMD_CHECK   = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_STALE = 2'd2;

    localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(SLOT_COUNT);

    typedef struct packed {
        logic [VERSION_BITS-1:0] ver;
        logic                    live;
    } t_slot_entry;

    typedef struct packed {
        logic                en;
        logic [IDX_BITS-1:0] addr;
        t_slot_entry         data;
    } t_slot_wr;

    typedef struct packed {
        logic                push;
        logic                pop;
        logic [IDX_BITS-1:0] push_idx;
    } t_stk_op;

endpackage

// File: src/ghal_slot_ram.sv
// Per-slot version and live mark store, one write and one registered read port.
module ghal_slot_ram (
    input  logic                          i_clk,
    input  ghal_pkg::t_slot_wr            i_wr,
    input  logic [ghal_pkg::IDX_BITS-1:0] i_rd_addr,
    output ghal_pkg::t_slot_entry         o_rd_data
);
    import ghal_pkg::*;

    t_slot_entry mem [SLOT_COUNT];
    t_slot_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/ghal_free_stack.sv
// Stack of freed slot indices with its fill count; top entry read every cycle.
module ghal_free_stack (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ghal_pkg::t_stk_op             i_op,
    output logic [ghal_pkg::IDX_BITS-1:0] o_top,
    output logic [ghal_pkg::CNT_BITS-1:0] o_count
);
    import ghal_pkg::*;

    logic [IDX_BITS-1:0] mem [SLOT_COUNT];
    logic [IDX_BITS-1:0] r_top;
    logic [CNT_BITS-1:0] r_count;
    logic [CNT_BITS-1:0] n_count;
    logic [CNT_BITS-1:0] top_pos;

    assign top_pos = r_count - CNT_BITS'(1);

    always_comb begin
        n_count = r_count;
        if (i_op.push) begin
            n_count = r_count + CNT_BITS'(1);
        end else if (i_op.pop) begin
            n_count = r_count - CNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.push) begin
            mem[r_count[IDX_BITS-1:0]] <= i_op.push_idx;
        end
        r_top <= mem[top_pos[IDX_BITS-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_top   = r_top;
    assign o_count = r_count;

endmodule

// File: src/generational_handle_allocator_core.sv
// Generational handle allocator: command sequencer around slot store and free stack.
// Steps: accept registers the command; LOOK decides it from the registered slot-store read;
// a new that reuses a freed slot adds POP, since the registered read of the slot store must
// be addressed with the index popped from the free stack. No new transaction is taken while busy.
// busy is low again in the cycle the result is shown; the receiver cannot stall.
// Reset (i_rst_n, synchronous): slot and stack counts cleared; memories need no clearing.
module generational_handle_allocator_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       i_cmd,
    input  logic [ghal_pkg::HANDLE_BITS-1:0] i_handle_in,
    output logic                             o_valid,
    output logic [ghal_pkg::HANDLE_BITS-1:0] o_handle_out,
    output logic [1:0]                       o_status
);
    import ghal_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOOK = 3'b010,
        ST_POP  = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [1:0]             r_cmd;
    logic [HANDLE_BITS-1:0] r_handle;
    logic [IDX_BITS-1:0]    r_pop_idx, n_pop_idx;
    logic [CNT_BITS-1:0]    r_used, n_used;
    logic                   r_valid, n_valid;
    logic [HANDLE_BITS-1:0] r_hout, n_hout;
    logic [1:0]             r_status, n_status;

    logic                   accept;
    t_slot_wr               slot_wr;
    logic [IDX_BITS-1:0]    slot_rd_addr;
    t_slot_entry            slot_rd;
    t_stk_op                stk_op;
    logic [IDX_BITS-1:0]    stk_top;
    logic [CNT_BITS-1:0]    stk_count;

    logic [IDX_BITS-1:0]     h_idx;
    logic [VERSION_BITS-1:0] h_ver;
    logic                    current;

    assign accept = start && (r_state == ST_IDLE);
    assign busy   = (r_state != ST_IDLE);

    assign h_idx   = r_handle[IDX_BITS-1:0];
    assign h_ver   = r_handle[IDX_BITS +: VERSION_BITS];
    assign current = ({1'b0, h_idx} < r_used) && slot_rd.live && (slot_rd.ver == h_ver);

    assign slot_rd_addr = (r_state == ST_LOOK) ? stk_top : i_handle_in[IDX_BITS-1:0];

    ghal_slot_ram u_slot_ram (
        .i_clk     (i_clk),
        .i_wr      (slot_wr),
        .i_rd_addr (slot_rd_addr),
        .o_rd_data (slot_rd)
    );

    ghal_free_stack u_free_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (stk_op),
        .o_top   (stk_top),
        .o_count (stk_count)
    );

    always_comb begin
        n_state   = r_state;
        n_pop_idx = r_pop_idx;
        n_used    = r_used;
        n_valid   = 1'b0;
        n_hout    = r_hout;
        n_status  = r_status;
        slot_wr   = '0;
        stk_op    = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                n_state = ST_IDLE;
                if (r_cmd == CMD_NEW) begin
                    if (stk_count != '0) begin
                        stk_op.pop = 1'b1;
                        n_pop_idx  = stk_top;
                        n_state    = ST_POP;
                    end else if (r_used < CNT_MAX) begin
                        slot_wr.en        = 1'b1;
                        slot_wr.addr      = r_used[IDX_BITS-1:0];
                        slot_wr.data.ver  = '0;
                        slot_wr.data.live = 1'b1;
                        n_used   = r_used + CNT_BITS'(1);
                        n_valid  = 1'b1;
                        n_hout   = HANDLE_BITS'(r_used[IDX_BITS-1:0]);
                        n_status = STAT_OK;
                    end else begin
                        n_valid  = 1'b1;
                        n_hout   = '0;
                        n_status = STAT_FULL;
                    end
                end else if (r_cmd == CMD_DESTROY) begin
                    n_valid = 1'b1;
                    n_hout  = r_handle;
                    if (current) begin
                        slot_wr.en        = 1'b1;
                        slot_wr.addr      = h_idx;
                        slot_wr.data.ver  = slot_rd.ver + VERSION_BITS'(1);
                        slot_wr.data.live = 1'b0;
                        stk_op.push       = (stk_count != CNT_MAX);
                        stk_op.push_idx   = h_idx;
                        n_status = STAT_OK;
                    end else begin
                        n_status = STAT_STALE;
                    end
                end else begin
                    n_valid  = 1'b1;
                    n_hout   = r_handle;
                    n_status = current ? STAT_OK : STAT_STALE;
                end
            end
            ST_POP: begin
                n_state           = ST_IDLE;
                slot_wr.en        = 1'b1;
                slot_wr.addr      = r_pop_idx;
                slot_wr.data.ver  = slot_rd.ver;
                slot_wr.data.live = 1'b1;
                n_valid  = 1'b1;
                n_hout   = {slot_rd.ver, r_pop_idx};
                n_status = STAT_OK;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= i_cmd;
            r_handle <= i_handle_in;
        end
        r_pop_idx <= n_pop_idx;
        r_hout    <= n_hout;
        r_status  <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_used  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_valid <= n_valid;
        end
    end

    assign o_valid      = r_valid;
    assign o_handle_out = r_hout;
    assign o_status     = r_status;

endmodule

// File: src/ghal_checker.sv
// Port-level checks for the generational handle allocator, bound to the top level.
module ghal_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             o_valid,
    input logic [ghal_pkg::HANDLE_BITS-1:0] o_handle_out,
    input logic [1:0]                       o_status
);
    import ghal_pkg::*;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("transaction finished without a result");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == STAT_FULL) |-> (o_handle_out == '0))
        else $error("full status with nonzero handle");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == STAT_OK || o_status == STAT_FULL ||
                     o_status == STAT_STALE))
        else $error("undefined status code");

endmodule

bind generational_handle_allocator_core ghal_checker u_ghal_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_handle_out (o_handle_out),
    .o_status     (o_status)
);
